FILE: sv/byte_vm_instruction_execute_core_assert.svh
// Assertion macros for the core's top-level RTL file.
`ifndef BYTE_VM_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH
`define BYTE_VM_INSTRUCTION_EXECUTE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define BVM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BVM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BVM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/bvm_pkg.sv
package bvm_pkg;

  localparam int NUM_REGS = 16;
  localparam int REG_AW   = $clog2(NUM_REGS);
  localparam int DATA_W   = 8;
  localparam int PC_W     = 8;

  localparam logic [PC_W-1:0]   PC_STEP = PC_W'(2);
  localparam logic [REG_AW-1:0] REG_ACC = '0;

  localparam logic [7:0] OP_MOVC = 8'h04;
  localparam logic [7:0] OP_LSL  = 8'h05;
  localparam logic [7:0] OP_JMP  = 8'h07;
  localparam logic [7:0] OP_JFE  = 8'h0A;
  localparam logic [7:0] OP_RET  = 8'h0B;
  localparam logic [7:0] OP_SUB  = 8'h0D;
  localparam logic [7:0] OP_XOR  = 8'h0E;
  localparam logic [7:0] OP_OR   = 8'h0F;
  localparam logic [7:0] OP_IN   = 8'h10;
  localparam logic [7:0] OP_OUT  = 8'h11;

  typedef struct packed {
    logic [7:0]        command;
    logic [7:0]        operand;
    logic [DATA_W-1:0] in_byte;
    logic              in_at_end;
  } instr_t;

  typedef struct packed {
    logic              out_valid;
    logic [DATA_W-1:0] out_byte;
    logic [PC_W-1:0]   next_pc;
    logic              halted;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [REG_AW-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              end_flag;
    logic [PC_W-1:0]   pc;
    logic              stopped;
    result_t           res;
  } exec_t;

endpackage

FILE: sv/bvm_ram.sv
module bvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-edge collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: sv/bvm_exec.sv
module bvm_exec import bvm_pkg::*; (
  input  instr_t            op,
  input  logic [DATA_W-1:0] rx_val,
  input  logic [DATA_W-1:0] ry_val,
  input  logic              end_flag,
  input  logic [PC_W-1:0]   pc,
  input  logic              stopped,
  output exec_t             ex
);

  logic jump;

  always_comb begin
    ex           = '0;
    jump         = 1'b0;
    ex.waddr     = op.operand[REG_AW-1:0];
    ex.end_flag  = end_flag;
    ex.stopped   = stopped;
    if (!stopped) begin
      case (op.command)
        OP_MOVC: begin
          ex.we    = 1'b1;
          ex.waddr = REG_ACC;
          ex.wdata = op.operand;
        end
        OP_LSL: begin
          ex.we    = 1'b1;
          ex.wdata = {rx_val[DATA_W-2:0], 1'b0};
        end
        OP_JMP:  jump = 1'b1;
        OP_JFE:  jump = end_flag;
        OP_RET:  ex.stopped = 1'b1;
        OP_SUB: begin
          ex.we    = 1'b1;
          ex.wdata = rx_val - ry_val;
        end
        OP_XOR: begin
          ex.we    = 1'b1;
          ex.wdata = rx_val ^ ry_val;
        end
        OP_OR: begin
          ex.we    = 1'b1;
          ex.wdata = rx_val | ry_val;
        end
        OP_IN: begin
          if (op.in_at_end) begin
            ex.end_flag = 1'b1;
          end else begin
            ex.we       = 1'b1;
            ex.wdata    = op.in_byte;
            ex.end_flag = 1'b0;
          end
        end
        OP_OUT: begin
          if (!end_flag) begin
            ex.res.out_valid = 1'b1;
            ex.res.out_byte  = rx_val;
          end
        end
        default: ;
      endcase
    end
    // signed jump offset wraps the same as an unsigned add mod 256
    if (stopped) begin
      ex.pc = pc;
    end else if (jump) begin
      ex.pc = pc + op.operand;
    end else begin
      ex.pc = pc + PC_STEP;
    end
    ex.res.next_pc = ex.pc;
    ex.res.halted  = ex.stopped;
  end

endmodule

FILE: sv/byte_vm_instruction_execute_core.sv
// Byte VM execute core: runs one two-byte instruction per transfer against
// sixteen 8-bit registers, an end-of-input flag, the program counter and a
// halt flag.
// Instruction channel: instr_valid / instr_stall carrying instr (command,
// operand, in_byte, in_at_end). Result channel: result_valid / result_stall
// carrying result (out_valid, out_byte, next_pc, halted); one result per
// instruction, in order.
// The instruction is registered into the execute stage, then its result into the result register.
// Throughput: one instruction per cycle while the receiver does not stall;
// the register file read is registered at acceptance and a write from the
// preceding instruction on the same edge is forwarded.
// Reset (rst, synchronous) clears registers (via per-entry valid bits), flags,
// counter and both pipeline stages; no clearing pass is needed.
// When the receiver stalls, the result register holds and the execute stage
// holds its instruction; instr_stall rises only once both are occupied.
// After RET every further instruction changes nothing and reports halted.
`include "byte_vm_instruction_execute_core_assert.svh"

module byte_vm_instruction_execute_core import bvm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    instr_valid,
  output logic    instr_stall,
  input  instr_t  instr,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic                 s1_full;
  instr_t               s1;
  logic                 accept;
  logic                 advance;
  logic                 wr;
  exec_t                ex;
  logic [NUM_REGS-1:0]  rf_valid;
  logic [DATA_W-1:0]    rdata_a;
  logic [DATA_W-1:0]    rdata_b;
  logic                 byp_x;
  logic                 byp_y;
  logic [DATA_W-1:0]    byp_data;
  logic                 vld_x;
  logic                 vld_y;
  logic [DATA_W-1:0]    rx_val;
  logic [DATA_W-1:0]    ry_val;
  logic                 end_flag;
  logic [PC_W-1:0]      pc;
  logic                 stopped;
  logic [REG_AW-1:0]    rx_in;
  logic [REG_AW-1:0]    ry_in;
  logic                 plain_step;

  assign advance     = s1_full && (!result_valid || !result_stall);
  assign instr_stall = s1_full && !advance;
  assign accept      = instr_valid && !instr_stall;
  assign wr          = advance && ex.we;
  assign rx_in       = instr.operand[REG_AW-1:0];
  assign ry_in       = instr.operand[2*REG_AW-1:REG_AW];

  bvm_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_rf (
    .clk     (clk),
    .we      (wr),
    .waddr   (ex.waddr),
    .wdata   (ex.wdata),
    .re      (accept),
    .raddr_a (rx_in),
    .raddr_b (ry_in),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1       <= instr;
      byp_x    <= wr && (ex.waddr == rx_in);
      byp_y    <= wr && (ex.waddr == ry_in);
      byp_data <= ex.wdata;
      vld_x    <= rf_valid[rx_in];
      vld_y    <= rf_valid[ry_in];
    end
  end

  assign rx_val = byp_x ? byp_data : (vld_x ? rdata_a : '0);
  assign ry_val = byp_y ? byp_data : (vld_y ? rdata_b : '0);

  bvm_exec u_exec (
    .op       (s1),
    .rx_val   (rx_val),
    .ry_val   (ry_val),
    .end_flag (end_flag),
    .pc       (pc),
    .stopped  (stopped),
    .ex       (ex)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full  <= 1'b0;
      rf_valid <= '0;
      end_flag <= 1'b0;
      pc       <= '0;
      stopped  <= 1'b0;
    end else begin
      if (accept) begin
        s1_full <= 1'b1;
      end else if (advance) begin
        s1_full <= 1'b0;
      end
      if (wr) begin
        rf_valid[ex.waddr] <= 1'b1;
      end
      if (advance) begin
        end_flag <= ex.end_flag;
        pc       <= ex.pc;
        stopped  <= ex.stopped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= ex.res;
    end
  end

  assign plain_step = advance && !stopped && s1.command != OP_JMP && s1.command != OP_JFE;

  `BVM_ASSERT_IMPLIES(a_quiet_byte, clk, rst, result_valid && !result.out_valid, result.out_byte == '0)
  `BVM_ASSERT_NEXT(a_halt_sticky, clk, rst, stopped, stopped)
  `BVM_ASSERT_NEXT(a_halt_pc_frozen, clk, rst, stopped, $stable(pc))
  `BVM_ASSERT_IMPLIES(a_full_stalls, clk, rst, s1_full && result_valid && result_stall, instr_stall)
  `BVM_ASSERT_NEXT(a_step_pc, clk, rst, plain_step, pc == $past(pc) + PC_STEP)

endmodule
